// ===== rtl/tlp_pkg.sv =====
package tlp_pkg;

    // Parameter defaults
    localparam int LINE_CAPACITY_DEF = 32;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_TIMEOUT      = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;
    localparam logic [15:0] TIMEOUT_RST      = 16'd200;

    // Action codes
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;

    // Characters
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // Parser constants
    localparam logic [3:0]  PH_LAST     = 4'd14;
    localparam int          NTGT_LEN    = 9;
    localparam logic [15:0] SILENCE_MAX = 16'hFFFF;
    localparam logic [19:0] VALUE_MAX   = 20'd65535;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic        frame_ready;
        logic        line_valid;
        logic        tgt_present;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic        link_alive;
    } t_out;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
    } t_box;

    // Line events from the parser to the frame tracker
    typedef struct packed {
        logic line_ok;
        logic set_target;
        logic clear_target;
    } t_line_evt;

    // Target line template, '#' marks a decimal field
    function automatic logic [7:0] pattern_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "X";
            4'd1:    ch = ":";
            4'd2:    ch = CH_HASH;
            4'd3:    ch = ",";
            4'd4:    ch = "Y";
            4'd5:    ch = ":";
            4'd6:    ch = CH_HASH;
            4'd7:    ch = ",";
            4'd8:    ch = "W";
            4'd9:    ch = ":";
            4'd10:   ch = CH_HASH;
            4'd11:   ch = ",";
            4'd12:   ch = "H";
            4'd13:   ch = ":";
            4'd14:   ch = CH_HASH;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // No-target keyword
    function automatic logic [7:0] ntgt_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "N";
            4'd1:    ch = "O";
            4'd2:    ch = "_";
            4'd3:    ch = "T";
            4'd4:    ch = "A";
            4'd5:    ch = "R";
            4'd6:    ch = "G";
            4'd7:    ch = "E";
            4'd8:    ch = "T";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/tlp_line_parser.sv =====
module tlp_line_parser #(
    parameter int LINE_CAPACITY = tlp_pkg::LINE_CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_rx_byte,
    input  logic [15:0]         i_image_width,
    input  logic [15:0]         i_image_height,
    output tlp_pkg::t_line_evt  o_evt,
    output tlp_pkg::t_box       o_box
);
    import tlp_pkg::*;

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_NTGT = CNT_W'(NTGT_LEN);

    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0]       r_phase, n_phase;
    logic [15:0]      r_acc, n_acc;
    logic             r_seen, n_seen;
    logic             r_bad, n_bad;
    logic             r_ntm, n_ntm;
    logic [15:0]      r_pend_cx, n_pend_cx;
    logic [15:0]      r_pend_cy, n_pend_cy;
    logic [15:0]      r_pend_w, n_pend_w;

    logic [19:0] acc_next;
    logic        is_digit;
    logic [7:0]  pat;
    logic        range_ok;

    // Decimal step: acc * 10 + digit
    assign is_digit = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_9);
    assign acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + {16'b0, i_rx_byte[3:0]};
    assign pat = pattern_char(r_phase);

    // Candidate box: the last field is still in the accumulator
    assign o_box = '{cx: r_pend_cx, cy: r_pend_cy, w: r_pend_w, h: r_acc};

    assign range_ok = (r_pend_cx < i_image_width) && (r_pend_cy < i_image_height)
                   && (r_pend_w != 16'd0) && (r_acc != 16'd0)
                   && (r_pend_w <= i_image_width) && (r_acc <= i_image_height);

    // Per-character parse step
    always_comb begin
        n_count   = r_count;
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_seen    = r_seen;
        n_bad     = r_bad;
        n_ntm     = r_ntm;
        n_pend_cx = r_pend_cx;
        n_pend_cy = r_pend_cy;
        n_pend_w  = r_pend_w;
        o_evt     = '0;
        if (i_en) begin
            if (i_rx_byte == CH_LF) begin
                if (r_count != '0) begin
                    if (!r_bad && r_phase == PH_LAST && r_seen) begin
                        if (range_ok) begin
                            o_evt.line_ok    = 1'b1;
                            o_evt.set_target = 1'b1;
                        end
                    end else if (r_ntm && r_count == CNT_NTGT) begin
                        o_evt.line_ok      = 1'b1;
                        o_evt.clear_target = 1'b1;
                    end
                    // Start a fresh line
                    n_count = '0;
                    n_phase = '0;
                    n_acc   = '0;
                    n_seen  = 1'b0;
                    n_bad   = 1'b0;
                    n_ntm   = 1'b1;
                end
            end else if (i_rx_byte != CH_CR && r_count != CNT_LAST) begin
                if (!(r_count < CNT_NTGT && i_rx_byte == ntgt_char(r_count[3:0]))) begin
                    n_ntm = 1'b0;
                end
                if (!r_bad) begin
                    if (pat == CH_HASH) begin
                        if (is_digit) begin
                            if (acc_next > VALUE_MAX) begin
                                n_bad = 1'b1;
                            end else begin
                                n_acc  = acc_next[15:0];
                                n_seen = 1'b1;
                            end
                        end else if (!r_seen || r_phase >= PH_LAST) begin
                            n_bad = 1'b1;
                        end else begin
                            // Close the field and expect the separator
                            case (r_phase[3:2])
                                2'd0:    n_pend_cx = r_acc;
                                2'd1:    n_pend_cy = r_acc;
                                2'd2:    n_pend_w  = r_acc;
                                default: n_pend_w  = r_pend_w;
                            endcase
                            n_acc  = '0;
                            n_seen = 1'b0;
                            if (pattern_char(r_phase + 4'd1) == i_rx_byte) begin
                                n_phase = r_phase + 4'd2;
                            end else begin
                                n_phase = r_phase + 4'd1;
                                n_bad   = 1'b1;
                            end
                        end
                    end else if (pat == i_rx_byte) begin
                        n_phase = r_phase + 4'd1;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_phase   <= '0;
            r_acc     <= '0;
            r_seen    <= 1'b0;
            r_bad     <= 1'b0;
            r_ntm     <= 1'b1;
            r_pend_cx <= '0;
            r_pend_cy <= '0;
            r_pend_w  <= '0;
        end else begin
            r_count   <= n_count;
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_seen    <= n_seen;
            r_bad     <= n_bad;
            r_ntm     <= n_ntm;
            r_pend_cx <= n_pend_cx;
            r_pend_cy <= n_pend_cy;
            r_pend_w  <= n_pend_w;
        end
    end

endmodule

// ===== rtl/tlp_frame_track.sv =====
module tlp_frame_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [1:0]          i_action,
    input  tlp_pkg::t_line_evt  i_evt,
    input  tlp_pkg::t_box       i_box,
    input  logic [15:0]         i_timeout,
    output tlp_pkg::t_out       o_res
);
    import tlp_pkg::*;

    t_box        r_frame, n_frame;
    logic        r_target, n_target;
    logic        r_pending, n_pending;
    logic        r_seen, n_seen;
    logic [15:0] r_silence, n_silence;

    // Update frame, flags and silence counter for one word
    always_comb begin
        n_frame   = r_frame;
        n_target  = r_target;
        n_pending = r_pending;
        n_seen    = r_seen;
        n_silence = r_silence;
        if (i_en) begin
            case (i_action)
                ACT_BYTE: begin
                    if (i_evt.set_target) begin
                        n_frame  = i_box;
                        n_target = 1'b1;
                    end
                    if (i_evt.clear_target) begin
                        n_target = 1'b0;
                    end
                    if (i_evt.line_ok) begin
                        n_silence = '0;
                        n_seen    = 1'b1;
                        n_pending = 1'b1;
                    end
                end
                ACT_TICK: begin
                    if (r_silence != SILENCE_MAX) begin
                        n_silence = r_silence + 16'd1;
                    end
                end
                ACT_FETCH: n_pending = 1'b0;
                default:   n_pending = r_pending;
            endcase
        end
    end

    // Result word reflects state after this word; frame_ready shows the pending flag from before it
    always_comb begin
        o_res.frame_ready = r_pending;
        o_res.line_valid  = i_evt.line_ok;
        o_res.tgt_present = n_target;
        o_res.center_x    = n_frame.cx;
        o_res.center_y    = n_frame.cy;
        o_res.box_width   = n_frame.w;
        o_res.box_height  = n_frame.h;
        o_res.link_alive  = n_seen && (n_silence < i_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame   <= '0;
            r_target  <= 1'b0;
            r_pending <= 1'b0;
            r_seen    <= 1'b0;
            r_silence <= TIMEOUT_RST;
        end else begin
            r_frame   <= n_frame;
            r_target  <= n_target;
            r_pending <= n_pending;
            r_seen    <= n_seen;
            r_silence <= n_silence;
        end
    end

endmodule

// ===== rtl/target_line_parser_with_link_timeout_top.sv =====
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+--------------------------
// input    | in        | i_in_valid / o_in_ready    | i_in_data  (t_in)
// result   | out       | o_out_valid / i_out_ready  | o_out_data (t_out)
// config   | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One word per cycle unless the result stalls: an input register feeds the parser
// and frame tracker, whose combinational logic loads the result register.
// The input register takes one more word while the result register waits.
// Reset is synchronous and active low; no clearing pass is needed.
// When the result is stalled the pipeline holds at most two words.
module target_line_parser_with_link_timeout_top #(
    parameter int LINE_CAPACITY = tlp_pkg::LINE_CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tlp_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tlp_pkg::t_out                    o_out_data,
    input  logic                             i_cfg_we,
    input  logic [tlp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tlp_pkg::*;

    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;
    logic [15:0] r_image_width;
    logic [15:0] r_image_height;
    logic [15:0] r_timeout;

    logic        advance;
    t_line_evt   evt;
    t_box        box;
    t_out        res;

    // Move the held word into the result register when it is free
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_timeout      <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data;
                default:          r_timeout      <= r_timeout;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    tlp_line_parser #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance && r_in.action == ACT_BYTE),
        .i_rx_byte      (r_in.rx_byte),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_evt          (evt),
        .o_box          (box)
    );

    tlp_frame_track u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_action  (r_in.action),
        .i_evt     (evt),
        .i_box     (box),
        .i_timeout (r_timeout),
        .o_res     (res)
    );

endmodule

// ===== rtl/tlp_checker.sv =====
module tlp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input tlp_pkg::t_out o_out_data
);
    import tlp_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    // A latched target box always has nonzero size
    a_box_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.line_valid && o_out_data.tgt_present
        |-> o_out_data.box_width != 16'd0 && o_out_data.box_height != 16'd0)
        else $error("latched box with zero size");

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

endmodule

bind target_line_parser_with_link_timeout_top tlp_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== verif/tb_target_line_parser_with_link_timeout_top.sv =====
module tb_target_line_parser_with_link_timeout_top;

    import tlp_pkg::*;

    localparam int LINE_CAP       = LINE_CAPACITY_DEF;
    localparam int CLK_PERIOD     = 12;
    localparam int RST_CYCLES     = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int RUN_LIMIT      = 3_000_000;
    localparam int FIELD_MAX      = 65535;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // Clock, reset and block ports
    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_word;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    target_line_parser_with_link_timeout_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Parser mirror: configuration copy
    logic [15:0] cfg_w;
    logic [15:0] cfg_h;
    logic [15:0] cfg_to;

    // Parser mirror: line state
    string       tmpl_text = "X:#,Y:#,W:#,H:#";
    string       kw_text   = "NO_TARGET";
    int          line_len;
    int          tmpl_pos;
    int          acc;
    logic        have_digit;
    logic [15:0] held [3];
    logic        bad;
    logic        kw_match;

    // Parser mirror: frame state
    t_box        box_q;
    logic        tgt_flag;
    logic        pend_flag;
    logic        seen_flag;
    logic [15:0] silence;

    // Stimulus and checking state
    t_in         pending_words [$];
    t_out        expected_reports [$];
    int          words_queued = 0;
    int          fail_count   = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    bit          idle_on      = 1'b1;

    function automatic void clear_line_state();
        line_len   = 0;
        tmpl_pos   = 0;
        acc        = 0;
        have_digit = 1'b0;
        bad        = 1'b0;
        kw_match   = 1'b1;
    endfunction

    function automatic void init_mirror();
        cfg_w  = IMAGE_WIDTH_RST;
        cfg_h  = IMAGE_HEIGHT_RST;
        cfg_to = TIMEOUT_RST;
        clear_line_state();
        for (int i = 0; i < 3; i++) held[i] = '0;
        box_q     = '0;
        tgt_flag  = 1'b0;
        pend_flag = 1'b0;
        seen_flag = 1'b0;
        silence   = TIMEOUT_RST;
    endfunction

    // Advance the template match by one stored character
    function automatic void take_char(logic [7:0] c);
        logic       is_dig;
        logic [7:0] t;
        is_dig = (c >= CH_0) && (c <= CH_9);
        if (!(line_len < NTGT_LEN && c == kw_text[line_len]))
            kw_match = 1'b0;
        if (!bad) begin
            t = tmpl_text[tmpl_pos];
            if (t == CH_HASH) begin
                if (is_dig) begin
                    acc = acc * 10 + (int'(c) - int'(CH_0));
                    if (acc > FIELD_MAX)
                        bad = 1'b1;
                    else
                        have_digit = 1'b1;
                end else if (!have_digit || tmpl_pos >= int'(PH_LAST)) begin
                    bad = 1'b1;
                end else begin
                    held[tmpl_pos >> 2] = 16'(acc);
                    acc        = 0;
                    have_digit = 1'b0;
                    tmpl_pos++;
                    if (tmpl_text[tmpl_pos] == c)
                        tmpl_pos++;
                    else
                        bad = 1'b1;
                end
            end else if (t == c) begin
                tmpl_pos++;
            end else begin
                bad = 1'b1;
            end
        end
        line_len++;
    endfunction

    // Judge the finished line and latch the frame
    function automatic logic close_line();
        logic        ok;
        logic [15:0] h;
        ok = 1'b0;
        h  = 16'(acc);
        if (!bad && tmpl_pos == int'(PH_LAST) && have_digit) begin
            if (held[0] < cfg_w && held[1] < cfg_h && held[2] != 0 && h != 0 &&
                held[2] <= cfg_w && h <= cfg_h) begin
                box_q    = '{cx: held[0], cy: held[1], w: held[2], h: h};
                tgt_flag = 1'b1;
                ok       = 1'b1;
            end
        end else if (kw_match && line_len == NTGT_LEN) begin
            tgt_flag = 1'b0;
            ok       = 1'b1;
        end
        if (ok) begin
            silence   = '0;
            seen_flag = 1'b1;
            pend_flag = 1'b1;
        end
        clear_line_state();
        return ok;
    endfunction

    // Compute the report for one accepted word
    function automatic t_out predict_report(t_in w);
        logic was_pending;
        logic line_ok;
        t_out r;
        was_pending = pend_flag;
        line_ok     = 1'b0;
        case (w.action)
            ACT_BYTE: begin
                if (w.rx_byte == CH_LF) begin
                    if (line_len > 0) line_ok = close_line();
                end else if (w.rx_byte != CH_CR && line_len < LINE_CAP - 1) begin
                    take_char(w.rx_byte);
                end
            end
            ACT_TICK: begin
                if (silence != SILENCE_MAX) silence++;
            end
            ACT_FETCH: begin
                pend_flag = 1'b0;
            end
            default: ;
        endcase
        r.frame_ready = was_pending;
        r.line_valid  = line_ok;
        r.tgt_present = tgt_flag;
        r.center_x    = box_q.cx;
        r.center_y    = box_q.cy;
        r.box_width   = box_q.w;
        r.box_height  = box_q.h;
        r.link_alive  = seen_flag && (silence < cfg_to);
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic string show_report(t_out r);
        return $sformatf("ready=%0b valid=%0b tgt=%0b box=(%0d,%0d,%0d,%0d) alive=%0b",
                         r.frame_ready, r.line_valid, r.tgt_present, r.center_x,
                         r.center_y, r.box_width, r.box_height, r.link_alive);
    endfunction

    function automatic string field_diffs(t_out want, t_out got);
        string s;
        s = "";
        if (got.frame_ready !== want.frame_ready) s = {s, " frame_ready"};
        if (got.line_valid  !== want.line_valid)  s = {s, " line_valid"};
        if (got.tgt_present !== want.tgt_present) s = {s, " tgt_present"};
        if (got.center_x    !== want.center_x)    s = {s, " center_x"};
        if (got.center_y    !== want.center_y)    s = {s, " center_y"};
        if (got.box_width   !== want.box_width)   s = {s, " box_width"};
        if (got.box_height  !== want.box_height)  s = {s, " box_height"};
        if (got.link_alive  !== want.link_alive)  s = {s, " link_alive"};
        return s;
    endfunction

    // Drive input words from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && in_ready)
                expected_reports.push_back(predict_report(in_word));
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    in_valid <= 1'b1;
                    in_word  <= pending_words.pop_front();
                    gap_left = idle_on ? pick_gap() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check result words and pace the sink
    always @(posedge i_clk) begin
        t_out  want;
        string diffs;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result at %0t: %s", $realtime, show_report(out_word));
            end else begin
                want  = expected_reports.pop_front();
                diffs = field_diffs(want, out_word);
                if (diffs != "") begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch at %0t in%s", $realtime, diffs);
                        $display("  expected %s", show_report(want));
                        $display("  actual   %s", show_report(out_word));
                    end
                end
            end
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    task automatic push_word(logic [1:0] act, logic [7:0] b);
        t_in w;
        w.action  = act;
        w.rx_byte = b;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic send_line(string s, bit add_cr);
        for (int i = 0; i < s.len(); i++) begin
            if (add_cr && $urandom_range(0, 7) == 0) push_word(ACT_BYTE, CH_CR);
            push_word(ACT_BYTE, s[i]);
        end
        if (add_cr && $urandom_range(0, 3) == 0) push_word(ACT_BYTE, CH_CR);
        push_word(ACT_BYTE, CH_LF);
    endtask

    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++) push_word(ACT_TICK, 8'($urandom));
    endtask

    // Hold until every word is out and the pipeline has emptied
    task automatic wait_drain();
        @(negedge i_clk);
        while (pending_words.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] v);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_w  = v;
            CFG_IMAGE_HEIGHT: cfg_h  = v;
            CFG_TIMEOUT:      cfg_to = v;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] w, logic [15:0] h, logic [15:0] to);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_TIMEOUT, to);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic string num_text(int v);
        if ($urandom_range(0, 9) == 0) return $sformatf("0%0d", v);
        return $sformatf("%0d", v);
    endfunction

    function automatic string target_text(int cx, int cy, int w, int h);
        return $sformatf("X:%s,Y:%s,W:%s,H:%s", num_text(cx), num_text(cy),
                         num_text(w), num_text(h));
    endfunction

    // Pick a field value, leaning on the limits of the image size
    function automatic int pick_val(int lim, bit is_size);
        case ($urandom_range(0, 11))
            0: return 0;
            1: return lim;
            2: return (lim > 0) ? lim - 1 : 0;
            3: return FIELD_MAX;
            4: return lim + 1;
            default: begin
                if (lim == 0) return 0;
                if (is_size) return $urandom_range(1, lim);
                return $urandom_range(0, lim - 1);
            end
        endcase
    endfunction

    function automatic string good_text();
        return target_text(pick_val(int'(cfg_w), 1'b0), pick_val(int'(cfg_h), 1'b0),
                           pick_val(int'(cfg_w), 1'b1), pick_val(int'(cfg_h), 1'b1));
    endfunction

    // Break a line: replace, delete, truncate, overflow, extend or misspell the keyword
    function automatic string corrupt_text(string s);
        int         pos;
        string      t;
        logic [7:0] ch;
        pos = $urandom_range(0, s.len() - 1);
        case ($urandom_range(0, 5))
            0: begin
                ch = 8'($urandom_range(1, 255));
                t  = s;
                t.putc(pos, ch);
            end
            1: t = {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
            2: t = {s, ","};
            3: t = s.substr(0, pos);
            4: t = $sformatf("X:%0d,Y:1,W:1,H:1", $urandom_range(FIELD_MAX + 1, 99999));
            default: begin
                case ($urandom_range(0, 2))
                    0: t = "NO_TARGE";
                    1: t = "NO_TARGETS";
                    default: t = "NO-TARGET";
                endcase
            end
        endcase
        return t;
    endfunction

    task automatic push_noise();
        int n;
        n = $urandom_range(0, 45);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: push_word(ACT_TICK, 8'($urandom));
                1: push_word(ACT_FETCH, 8'($urandom));
                2: push_word(ACT_SPARE, 8'($urandom));
                default: push_word(ACT_BYTE, 8'($urandom_range(0, 255)));
            endcase
        end
        push_word(ACT_BYTE, CH_LF);
    endtask

    task automatic run_random(int count, bit with_pause);
        int base;
        int r;
        int burst;
        bit paused;
        base   = words_queued;
        paused = 1'b0;
        while (words_queued - base < count) begin
            // hold the sender once until the sink has caught up
            if (with_pause && !paused && words_queued - base >= count / 2) begin
                paused = 1'b1;
                wait_drain();
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_line(good_text(), 1'b1);
            end else if (r < 50) begin
                send_line("NO_TARGET", 1'b1);
            end else if (r < 62) begin
                send_line(corrupt_text(good_text()), 1'b1);
            end else if (r < 68) begin
                push_noise();
            end else if (r < 80) begin
                burst = $urandom_range(1, 8);
                if ($urandom_range(0, 7) == 0)
                    burst = (int'(cfg_to) < 300) ? int'(cfg_to) + 1 : 300;
                push_ticks(burst);
            end else if (r < 90) begin
                push_word(ACT_FETCH, 8'($urandom));
            end else if (r < 95) begin
                case ($urandom_range(0, 2))
                    0: push_word(ACT_SPARE, 8'($urandom));
                    1: push_word(ACT_BYTE, CH_LF);
                    default: push_word(ACT_BYTE, CH_CR);
                endcase
            end else begin
                send_line({good_text(), "0123456789ABCDEF"}, 1'b0);
            end
        end
    endtask

    // Ends a run that hangs
    initial begin
        #(RUN_LIMIT * CLK_PERIOD);
        $display("target_line_parser_with_link_timeout_top regression: fail");
        $finish;
    end

    initial begin
        init_mirror();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset configuration
        push_word(ACT_FETCH, 8'h00);
        push_word(ACT_TICK, 8'hFF);
        push_word(ACT_SPARE, 8'hFF);
        send_line("X:0,Y:0,W:1,H:1", 1'b0);
        push_word(ACT_FETCH, 8'hA5);
        push_word(ACT_FETCH, 8'h5A);
        send_line("X:639,Y:479,W:640,H:480", 1'b0);
        send_line("X:640,Y:0,W:1,H:1", 1'b0);
        send_line("NO_TAR\rGET\r", 1'b0);
        push_word(ACT_BYTE, CH_LF);
        send_line("\r", 1'b0);
        send_line("X:65536,Y:0,W:1,H:1", 1'b0);
        send_line("X:,Y:0,W:1,H:1", 1'b0);
        send_line("X:1,Y:2,W:3,H:4,", 1'b0);
        send_line("x:1,Y:2,W:3,H:4", 1'b0);
        send_line("X:1,Y:2,W:0,H:4", 1'b0);
        send_line("X:1,Y:2,W:3,H:", 1'b0);
        send_line("NO_TARGETX", 1'b0);
        send_line("NO_TARGE", 1'b0);
        send_line("X:00001,Y:00002,W:00003,H:00004JUNK", 1'b0);
        send_line("NO_TARGET                              ", 1'b0);
        push_ticks(int'(TIMEOUT_RST));
        wait_drain();

        // Largest configuration
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_on = 1'b0;
        send_line("X:65534,Y:65534,W:65535,H:65535", 1'b0);
        push_ticks(300);
        push_word(ACT_FETCH, 8'h00);
        send_line("NO_TARGET", 1'b0);
        wait_drain();

        // Random phases over several settings
        idle_on = 1'b1;
        set_config(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST, TIMEOUT_RST);
        run_random(150, 1'b0);
        wait_drain();

        set_config(16'd1, 16'd1, 16'd1);
        run_random(80, 1'b0);
        wait_drain();

        set_config(16'd0, 16'd0, 16'd0);
        run_random(60, 1'b0);
        wait_drain();

        set_config(16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
                   16'($urandom_range(1, 30)));
        run_random(150, 1'b1);
        wait_drain();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(80, 1'b0);
        wait_drain();

        set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 400)));
        run_random(80, 1'b0);
        wait_drain();

        idle_on = 1'b0;
        set_config(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST, TIMEOUT_RST);
        run_random(100, 1'b0);
        wait_drain();

        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("target_line_parser_with_link_timeout_top regression: pass");
        end else begin
            $display("target_line_parser_with_link_timeout_top regression: fail");
        end
        $finish;
    end

endmodule
